### hw/rtl/seven_bit_frame_deframer_unit_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef SEVEN_BIT_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define SEVEN_BIT_FRAME_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SBFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("deframer assertion failed");
`define SBFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("deframer assertion failed");
`else
`define SBFD_ASSERT(label, prop)
`define SBFD_ASSERT_ALWAYS(label, prop)
`endif
`endif

### hw/rtl/sbfd_pkg.sv
// Types and constants of the seven-bit frame deframer.
package sbfd_pkg;

  localparam int unsigned GROUP_W    = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HDR_BIT    = 7;
  localparam int unsigned STORED_CNT = 4;

  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [STORED_CNT-1:0][GROUP_W-1:0] group_set_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_G0   = 6'b000010,
    PH_G1   = 6'b000100,
    PH_G2   = 6'b001000,
    PH_G3   = 6'b010000,
    PH_G4   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic  match;
    word_t word;
  } frame_result_t;

endpackage

### hw/rtl/sbfd_frame_check.sv
// Checksum comparison and word packing for a completed frame.
module sbfd_frame_check import sbfd_pkg::*; (
  input  group_set_t    stored,
  input  group_t        last_group,
  input  group_t        expected,
  output frame_result_t result
);

  group_t sum;

  // The sum wraps in seven bits, which gives the modulo 128 checksum.
  assign sum = stored[0] + stored[1] + stored[2] + stored[3] + last_group;

  assign result.match = (sum == expected);
  assign result.word  = {stored[0][3:0], stored[1], stored[2], stored[3], last_group};

endmodule

### hw/rtl/seven_bit_frame_deframer_unit.sv
// Top level of the seven-bit frame deframer.
//
//   channel  direction  handshake                payload
//   rx       in         rx_valid / rx_stall      rx_byte [7:0]
//   word     out        word_valid / word_stall  word_value [31:0]
//
// One request is taken every cycle unless stalled; a matching frame's word is built
// from the input register and loads the result register once the latter is free.
// The input register feeds one level of phase, checksum and packing logic
// that loads the result register.
// rst clears the phase, the expected checksum and both valid flags.
// A held result stalls the input only when a new byte reaches the logic.
`include "seven_bit_frame_deframer_unit_macros.svh"
module seven_bit_frame_deframer_unit import sbfd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  rx_valid,
  output logic  rx_stall,
  input  byte_t rx_byte,
  output logic  word_valid,
  input  logic  word_stall,
  output word_t word_value
);

  logic          in_valid_q;
  byte_t         in_byte_q;
  logic          fire;
  phase_t        phase;
  phase_t        phase_next;
  group_t        expected_sum;
  group_t        expected_sum_next;
  group_set_t    groups;
  logic          load_result;
  group_t        byte_group;
  logic          is_header;
  frame_result_t check;

  assign byte_group = in_byte_q[GROUP_W-1:0];
  assign is_header  = in_byte_q[HDR_BIT];
  assign fire       = in_valid_q && (!word_valid || !word_stall);
  assign rx_stall   = in_valid_q && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!rx_stall) begin
      in_valid_q <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      in_byte_q <= rx_byte;
    end
  end

  sbfd_frame_check u_check (
    .stored     (groups),
    .last_group (byte_group),
    .expected   (expected_sum),
    .result     (check)
  );

  always_comb begin
    phase_next        = phase;
    expected_sum_next = expected_sum;
    load_result       = 1'b0;
    if (fire) begin
      if (is_header) begin
        phase_next        = PH_G0;
        expected_sum_next = byte_group;
      end else begin
        unique case (phase)
          PH_G0:   phase_next = PH_G1;
          PH_G1:   phase_next = PH_G2;
          PH_G2:   phase_next = PH_G3;
          PH_G3:   phase_next = PH_G4;
          PH_G4: begin
            phase_next  = PH_IDLE;
            load_result = check.match;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      expected_sum <= '0;
    end else begin
      phase        <= phase_next;
      expected_sum <= expected_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_header) begin
      if (phase == PH_G0) begin
        groups[0] <= byte_group;
      end
      if (phase == PH_G1) begin
        groups[1] <= byte_group;
      end
      if (phase == PH_G2) begin
        groups[2] <= byte_group;
      end
      if (phase == PH_G3) begin
        groups[3] <= byte_group;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load_result) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      word_value <= check.word;
    end
  end

  `SBFD_ASSERT(a_stall_cause, rx_stall |-> (in_valid_q && word_valid && word_stall))
  `SBFD_ASSERT(a_result_after_last, $rose(word_valid) |-> ($past(phase) == PH_G4))
  `SBFD_ASSERT(a_result_from_data, $rose(word_valid) |-> !$past(in_byte_q[HDR_BIT]))
  `SBFD_ASSERT(a_idle_after_result, $rose(word_valid) |-> (phase == PH_IDLE))
  `SBFD_ASSERT_ALWAYS(a_reset_clears, rst |=> (!word_valid && !in_valid_q))

endmodule
